### hdl/crc_checked_frame_parser_macros.svh
// Assertion macros used by the port-level checker of the frame parser.
`ifndef CRC_CHECKED_FRAME_PARSER_MACROS_SVH
`define CRC_CHECKED_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, disabled while the given reset term is high.
`define CFP_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while the given reset term is high.
`define CFP_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/cfp_pkg.sv
// Types, constants and the byte-wide CRC-32 update of the frame parser.
package cfp_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int MAX_LEN_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_MARKER = 2'd0,
    CFG_END_MARKER   = 2'd1,
    CFG_MAX_LENGTH   = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]           start_marker;
    logic [7:0]           end_marker;
    logic [MAX_LEN_W-1:0] max_length;
  } cfg_t;

  localparam logic [7:0]           START_MARKER_RST = 8'd170;
  localparam logic [7:0]           END_MARKER_RST   = 8'd85;
  localparam logic [MAX_LEN_W-1:0] MAX_LENGTH_RST   = 11'd1024;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_TYPE   = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_LEN_HI = 3'd3,
    PH_DATA   = 3'd4,
    PH_CRC    = 3'd5,
    PH_EOF    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_GOOD     = 3'd1,
    ST_CRC_BAD  = 3'd2,
    ST_NO_END   = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_t;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### hdl/cfp_cfg_regs.sv
// Configuration register file of the frame parser.
module cfp_cfg_regs
  import cfp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MAX_LEN_W-1:0] cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker <= START_MARKER_RST;
      cfg.end_marker   <= END_MARKER_RST;
      cfg.max_length   <= MAX_LENGTH_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START_MARKER: cfg.start_marker <= cfg_data[7:0];
        CFG_END_MARKER:   cfg.end_marker   <= cfg_data[7:0];
        CFG_MAX_LENGTH:   cfg.max_length   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

### hdl/crc_checked_frame_parser.sv
// An accepted byte goes to the input register, then its result item to the result
// register on the master side. Throughput: one byte per cycle unless the master side
// stalls; the byte-wide CRC-32 update between the two registers is combinational.
// Reset: synchronous, active high; clears both pipeline stages, the parser returns
// to hunting with its frame registers cleared and the configuration at its defaults.
module crc_checked_frame_parser
  import cfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MAX_LEN_W-1:0] cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // rx_byte
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // payload_byte[7:0], payload_index[17:8], frame_status[20:18], frame_type[28:21],
  // frame_length[44:29], received_crc[76:45], computed_crc[108:77], zero fill
  output logic [111:0]         m_tdata,
  output logic                 m_tuser    // payload_valid
);

  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  cfg_t cfg;

  cfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;

  phase_t      phase, phase_next, phase_upd;
  logic [7:0]  type_reg, type_next, type_upd;
  logic [15:0] length_reg, length_next, length_upd;
  logic [10:0] payload_count, payload_count_next, payload_count_upd;
  logic [1:0]  crc_byte_count, crc_byte_count_next, crc_byte_count_upd;
  logic [31:0] crc_field, crc_field_next, crc_field_upd;
  logic [31:0] crc_running, crc_running_next, crc_running_upd;

  logic        res_valid;
  logic [7:0]  res_byte;
  logic [9:0]  res_index;
  status_t     res_status;
  logic        finish;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  always_comb begin
    phase_upd          = phase;
    type_upd           = type_reg;
    length_upd         = length_reg;
    payload_count_upd  = payload_count;
    crc_byte_count_upd = crc_byte_count;
    crc_field_upd      = crc_field;
    crc_running_upd    = crc_running;
    res_valid          = 1'b0;
    res_byte           = 8'd0;
    res_index          = 10'd0;
    res_status         = ST_NONE;
    finish             = 1'b0;
    case (phase)
      PH_HUNT: begin
        if (in_byte == cfg.start_marker) begin
          phase_upd = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_upd  = in_byte;
        phase_upd = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_upd = {8'd0, in_byte};
        phase_upd  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_upd = {in_byte, length_reg[7:0]};
        if (length_upd > {5'd0, cfg.max_length} || length_upd > MAX_LEN) begin
          res_status = ST_TOO_LONG;
          finish     = 1'b1;
        end else begin
          payload_count_upd  = 11'd0;
          crc_byte_count_upd = 2'd0;
          crc_field_upd      = 32'd0;
          crc_running_upd    = CRC_INIT;
          phase_upd          = (length_upd != 16'd0) ? PH_DATA : PH_CRC;
        end
      end
      PH_DATA: begin
        res_valid         = 1'b1;
        res_byte          = in_byte;
        res_index         = payload_count[9:0];
        crc_running_upd   = crc32_byte(crc_running, in_byte);
        payload_count_upd = payload_count + 11'd1;
        if ({5'd0, payload_count_upd} >= length_reg) begin
          crc_byte_count_upd = 2'd0;
          phase_upd          = PH_CRC;
        end
      end
      PH_CRC: begin
        case (crc_byte_count)
          2'd0:    crc_field_upd = crc_field | {24'd0, in_byte};
          2'd1:    crc_field_upd = crc_field | {16'd0, in_byte, 8'd0};
          2'd2:    crc_field_upd = crc_field | {8'd0, in_byte, 16'd0};
          default: crc_field_upd = crc_field | {in_byte, 24'd0};
        endcase
        crc_byte_count_upd = crc_byte_count + 2'd1;
        if (crc_byte_count_upd == 2'd0) begin
          phase_upd = PH_EOF;
        end
      end
      PH_EOF: begin
        if (in_byte != cfg.end_marker) begin
          res_status = ST_NO_END;
        end else if (~crc_running == crc_field) begin
          res_status = ST_GOOD;
        end else begin
          res_status = ST_CRC_BAD;
        end
        finish = 1'b1;
      end
      default: begin
        phase_upd = PH_HUNT;
      end
    endcase
  end

  always_comb begin
    if (finish) begin
      phase_next          = PH_HUNT;
      type_next           = 8'd0;
      length_next         = 16'd0;
      payload_count_next  = 11'd0;
      crc_byte_count_next = 2'd0;
      crc_field_next      = 32'd0;
      crc_running_next    = CRC_INIT;
    end else begin
      phase_next          = phase_upd;
      type_next           = type_upd;
      length_next         = length_upd;
      payload_count_next  = payload_count_upd;
      crc_byte_count_next = crc_byte_count_upd;
      crc_field_next      = crc_field_upd;
      crc_running_next    = crc_running_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      type_reg       <= 8'd0;
      length_reg     <= 16'd0;
      payload_count  <= 11'd0;
      crc_byte_count <= 2'd0;
      crc_field      <= 32'd0;
      crc_running    <= CRC_INIT;
    end else if (advance) begin
      phase          <= phase_next;
      type_reg       <= type_next;
      length_reg     <= length_next;
      payload_count  <= payload_count_next;
      crc_byte_count <= crc_byte_count_next;
      crc_field      <= crc_field_next;
      crc_running    <= crc_running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tuser <= res_valid;
      m_tdata <= {3'd0, ~crc_running_upd, crc_field_upd, length_upd, type_upd,
                  res_status, res_index, res_byte};
    end
  end

endmodule

### hdl/cfp_checker.sv
// Port-level assertion checker of the frame parser and its bind statement.
`include "crc_checked_frame_parser_macros.svh"

module cfp_checker
  import cfp_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata,
  input logic         m_tuser
);

  `CFP_ASSERT_NXT(a_reset_empty, clk, 1'b0, rst, !m_tvalid, "result item present after reset")
  `CFP_ASSERT_NXT(a_hold_stall, clk, rst, m_tvalid && !m_tready,
                  m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result item changed")
  `CFP_ASSERT_IMP(a_payload_no_status, clk, rst, m_tvalid && m_tuser,
                  m_tdata[20:18] == ST_NONE, "payload byte carries a frame status")
  `CFP_ASSERT_IMP(a_idle_zero, clk, rst, m_tvalid && !m_tuser,
                  m_tdata[17:0] == 18'd0, "non-payload item carries byte or index")
  `CFP_ASSERT_IMP(a_good_crc, clk, rst, m_tvalid && m_tdata[20:18] == ST_GOOD,
                  m_tdata[76:45] == m_tdata[108:77], "good frame with differing CRC values")

endmodule

bind crc_checked_frame_parser cfp_checker u_cfp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### dv/frame_parser_checker.sv
`timescale 1ns / 100ps
// Result checker of the frame parser: a byte-level parser model and a field-by-field compare.

package frame_tb_pkg;

  function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
    end
    return c;
  endfunction

endpackage

module frame_parser_checker
  import cfp_pkg::*;
  import frame_tb_pkg::*;
#(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MAX_LEN_W-1:0] cfg_data,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [7:0]           s_tdata,   // rx_byte
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  // payload_byte[7:0], payload_index[17:8], frame_status[20:18], frame_type[28:21],
  // frame_length[44:29], received_crc[76:45], computed_crc[108:77], zero fill
  input  logic [111:0]         m_tdata,
  input  logic                 m_tuser,   // payload_valid
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic        pv;
    logic [7:0]  pb;
    logic [9:0]  pi;
    status_t     st;
    logic [7:0]  ty;
    logic [15:0] ln;
    logic [31:0] rc;
    logic [31:0] cc;
  } frame_result_t;

  frame_result_t expected_q[$];
  int            mismatches;

  logic [7:0]           start_byte;
  logic [7:0]           end_byte;
  logic [MAX_LEN_W-1:0] len_limit;

  phase_t      phase;
  logic [7:0]  ftype_q;
  logic [15:0] flen_q;
  logic [10:0] pay_cnt;
  logic [1:0]  crc_bytes;
  logic [31:0] crc_rx;
  logic [31:0] crc_acc;

  function automatic void clear_frame();
    phase     = PH_HUNT;
    ftype_q   = '0;
    flen_q    = '0;
    pay_cnt   = '0;
    crc_bytes = '0;
    crc_rx    = '0;
    crc_acc   = '1;
  endfunction

  function automatic frame_result_t parse_byte(input logic [7:0] b);
    frame_result_t r;
    logic          done;
    r    = '0;
    done = 1'b0;
    case (phase)
      PH_HUNT: begin
        if (b == start_byte) phase = PH_TYPE;
      end
      PH_TYPE: begin
        ftype_q = b;
        phase   = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        flen_q = {8'd0, b};
        phase  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        flen_q = {b, flen_q[7:0]};
        if (flen_q > len_limit || flen_q > MAX_PAYLOAD) begin
          r.st = ST_TOO_LONG;
          done = 1'b1;
        end else begin
          pay_cnt   = '0;
          crc_bytes = '0;
          crc_rx    = '0;
          crc_acc   = '1;
          phase     = (flen_q != 0) ? PH_DATA : PH_CRC;
        end
      end
      PH_DATA: begin
        r.pv    = 1'b1;
        r.pb    = b;
        r.pi    = pay_cnt[9:0];
        crc_acc = crc32_next(crc_acc, b);
        pay_cnt = pay_cnt + 1'b1;
        if ({5'd0, pay_cnt} >= flen_q) begin
          crc_bytes = '0;
          phase     = PH_CRC;
        end
      end
      PH_CRC: begin
        crc_rx    = crc_rx | ({24'd0, b} << (8 * crc_bytes));
        crc_bytes = crc_bytes + 1'b1;
        if (crc_bytes == 0) phase = PH_EOF;
      end
      PH_EOF: begin
        if (b != end_byte) r.st = ST_NO_END;
        else if (~crc_acc == crc_rx) r.st = ST_GOOD;
        else r.st = ST_CRC_BAD;
        done = 1'b1;
      end
      default: begin
        phase = PH_HUNT;
      end
    endcase
    r.ty = ftype_q;
    r.ln = flen_q;
    r.rc = crc_rx;
    r.cc = ~crc_acc;
    if (done) clear_frame();
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (rst) begin
      expected_q.delete();
      mismatches = 0;
      start_byte = START_MARKER_RST;
      end_byte   = END_MARKER_RST;
      len_limit  = MAX_LENGTH_RST;
      clear_frame();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_START_MARKER: start_byte = cfg_data[7:0];
          CFG_END_MARKER:   end_byte   = cfg_data[7:0];
          CFG_MAX_LENGTH:   len_limit  = cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $error("result item with no expected result waiting");
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("payload_valid", 32'(want.pv), 32'(m_tuser));
          check_field("payload_byte", 32'(want.pb), 32'(m_tdata[7:0]));
          check_field("payload_index", 32'(want.pi), 32'(m_tdata[17:8]));
          check_field("frame_status", 32'(want.st), 32'(m_tdata[20:18]));
          check_field("frame_type", 32'(want.ty), 32'(m_tdata[28:21]));
          check_field("frame_length", 32'(want.ln), 32'(m_tdata[44:29]));
          check_field("received_crc", want.rc, m_tdata[76:45]);
          check_field("computed_crc", want.cc, m_tdata[108:77]);
        end
      end
      if (s_tvalid && s_tready) expected_q.push_back(parse_byte(s_tdata));
    end
    fail_count <= mismatches;
    pending    <= expected_q.size();
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top of the frame parser: clock, reset, frame stimulus, watchdog and verdict.
module tb_top;
  import cfp_pkg::*;
  import frame_tb_pkg::*;

  localparam int MAX_PAYLOAD = 1024;
  localparam int HANG_LIMIT  = 2000;
  localparam int PHASE_ITEMS = 120;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MAX_LEN_W-1:0] cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic [7:0]           s_tdata   = '0;
  logic                 m_tready  = 1'b0;
  logic                 cfg_ready;
  logic                 s_tready;
  logic                 m_tvalid;
  logic [111:0]         m_tdata;
  logic                 m_tuser;
  int                   fail_count;
  int                   pending;

  int         idle_pct     = 0;
  int         stall_pct    = 0;
  int         sent_total   = 0;
  int         quiet_cycles = 0;
  logic [7:0] cur_sm       = START_MARKER_RST;
  logic [7:0] cur_em       = END_MARKER_RST;
  logic [10:0] cur_ml      = MAX_LENGTH_RST;

  crc_checked_frame_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (.*);

  frame_parser_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_checker (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("crc_checked_frame_parser test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int frame_limit();
    return (cur_ml < MAX_PAYLOAD) ? int'(cur_ml) : MAX_PAYLOAD;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_total++;
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] flen,
                            input logic lead_marker, input logic bad_crc, input logic bad_end);
    logic [31:0] crc;
    logic [7:0]  b;
    logic [7:0]  tail;
    crc = 32'hFFFF_FFFF;
    send_byte(cur_sm);
    send_byte(ftype);
    send_byte(flen[7:0]);
    send_byte(flen[15:8]);
    if (int'(flen) > frame_limit()) return;
    for (int i = 0; i < int'(flen); i++) begin
      b = 8'($urandom_range(255));
      if ((lead_marker && i == 0) || $urandom_range(15) == 0) b = cur_sm;
      crc = crc32_next(crc, b);
      send_byte(b);
    end
    crc = ~crc;
    if (bad_crc) crc = crc ^ ($urandom() | 32'h1);
    for (int i = 0; i < 4; i++) send_byte(crc[8*i +: 8]);
    tail = bad_end ? (cur_em ^ 8'($urandom_range(1, 255))) : cur_em;
    send_byte(tail);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_put(input cfg_idx_t idx, input logic [10:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input logic [10:0] sm_raw, input logic [10:0] em_raw,
                            input logic [10:0] ml);
    cfg_put(CFG_START_MARKER, sm_raw);
    cfg_put(CFG_END_MARKER, em_raw);
    cfg_put(CFG_MAX_LENGTH, ml);
    cfg_put(CFG_UNUSED, 11'($urandom_range(2047)));
    cfg_valid <= 1'b0;
    cur_sm = sm_raw[7:0];
    cur_em = em_raw[7:0];
    cur_ml = ml;
  endtask

  initial begin : stimulus
    int          pick;
    int          lim;
    int          phase_end;
    logic [15:0] flen;
    logic [7:0]  ftype;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_frame(8'h00, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_frame(8'hFF, 16'd2, 1'b1, 1'b0, 1'b0);
    wait_idle();
    set_config(11'h700, 11'h7FF, 11'd0);
    send_frame(8'h12, 16'd0, 1'b0, 1'b0, 1'b0);
    send_frame(8'h34, 16'd1, 1'b0, 1'b0, 1'b0);
    wait_idle();

    set_config(11'($urandom_range(2047)), 11'($urandom_range(2047)), 11'd300);
    send_frame(8'($urandom_range(255)), 16'd300, 1'b0, 1'b0, 1'b0);

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0: set_config(11'($urandom_range(2047)), 11'($urandom_range(2047)), 11'd2047);
        1: set_config(11'($urandom_range(2047)), 11'($urandom_range(2047)),
                      11'($urandom_range(2047)));
        2: set_config(11'($urandom_range(2047)), 11'($urandom_range(2047)),
                      11'($urandom_range(24)));
        default: set_config(11'h0FF, 11'h700, 11'($urandom_range(2047)));
      endcase
      idle_pct  = (p == 1) ? 74 : (p == 3) ? 37 : 0;
      stall_pct = (p == 2) ? 74 : (p == 3) ? 37 : 0;
      phase_end = sent_total + PHASE_ITEMS;
      while (sent_total < phase_end) begin
        pick  = $urandom_range(99);
        ftype = 8'($urandom_range(255));
        lim   = frame_limit();
        if ($urandom_range(19) == 0) flen = 16'($urandom_range((lim < 64) ? lim : 64));
        else flen = 16'($urandom_range((lim < 12) ? lim : 12));
        if (pick < 60) begin
          send_frame(ftype, flen, 1'b0, 1'b0, 1'b0);
        end else if (pick < 70) begin
          send_frame(ftype, flen, 1'b0, 1'b1, 1'b0);
        end else if (pick < 78) begin
          send_frame(ftype, flen, 1'b0, 1'($urandom_range(1)), 1'b1);
        end else if (pick < 86) begin
          flen = $urandom_range(1) ? 16'(lim + 1) : 16'($urandom_range(65535, lim + 1));
          send_frame(ftype, flen, 1'b0, 1'b0, 1'b0);
        end else if (pick < 94) begin
          repeat ($urandom_range(1, 6)) begin
            send_byte(($urandom_range(3) == 0) ? cur_sm : 8'($urandom_range(255)));
          end
        end else begin
          send_byte(cur_sm);
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("crc_checked_frame_parser test passed");
    end else begin
      $display("crc_checked_frame_parser test failed");
    end
    $finish;
  end

endmodule
